// ===== rtl/assert_macros.svh =====
// Assertion shorthands for the RTL file that carries checks (the top level).
// Expects clk and rst_n (active low) in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lphm_pkg.sv =====
// Shared types and constants of the linear-probe hash map.
// No dependencies.
`default_nettype none

package lphm_pkg;

  // home slot is (key >> HOME_SHIFT) mod capacity
  localparam int unsigned HOME_SHIFT      = 4;
  // quotient bits folded into the remainder per cycle
  localparam int unsigned HASH_DIGIT_BITS = 4;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_MISS = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;
  localparam logic [1:0] STAT_ZERO = 2'd3;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE
  } state_t;

  typedef struct packed {
    logic wr_key;
    logic wr_val;
    logic rd_en;
  } mem_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/lphm_home.sv =====
// Home slot unit: (key >> HOME_SHIFT) mod CAPACITY.
// Mask for a power-of-two capacity, else a radix-16 remainder loop. Uses lphm_pkg.
`default_nettype none

module lphm_home #(
  parameter int unsigned CAPACITY = 512,
  parameter int unsigned KEY_BITS = 32,
  parameter int unsigned AW       = 9
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  go,
  input  wire [KEY_BITS-1:0]   key_in,
  output logic                 done,
  output logic [AW-1:0]        home
);
  import lphm_pkg::*;

  localparam bit IS_POW2 = ((CAPACITY & (CAPACITY - 1)) == 0);

  generate
    if (IS_POW2) begin : g_pow2
      localparam int unsigned XW = KEY_BITS + AW;
      logic [XW-1:0] kx;
      logic [AW-1:0] home_r;
      logic          done_r;

      assign kx = XW'(key_in) >> HOME_SHIFT;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r <= 1'b0;
        end else begin
          done_r <= go;
        end
      end

      always_ff @(posedge clk) begin
        if (go) begin
          home_r <= kx[AW-1:0];
        end
      end

      assign done = done_r;
      assign home = home_r;
    end else begin : g_serial
      localparam int unsigned R     = HASH_DIGIT_BITS;
      localparam int unsigned QW    = KEY_BITS - HOME_SHIFT;
      localparam int unsigned NSTEP = (QW + R - 1) / R;
      localparam int unsigned PW    = NSTEP * R;
      localparam int unsigned CW    = (NSTEP > 1) ? $clog2(NSTEP) : 1;
      localparam logic [AW:0] CAP_W = (AW + 1)'(CAPACITY);

      logic [PW-1:0] q_r;
      logic [AW-1:0] rem_r;
      logic [AW-1:0] rem_acc;
      logic [AW:0]   t;
      logic [CW-1:0] cnt_r;
      logic          run_r;
      logic          done_r;

      // fold one digit: R restoring steps on narrow values
      always_comb begin
        rem_acc = rem_r;
        t       = '0;
        for (int i = 0; i < R; i++) begin
          t = {rem_acc, q_r[PW-1-i]};
          if (t >= CAP_W) begin
            t = t - CAP_W;
          end
          rem_acc = t[AW-1:0];
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          run_r  <= 1'b0;
          done_r <= 1'b0;
          cnt_r  <= '0;
        end else begin
          done_r <= 1'b0;
          if (go) begin
            run_r <= 1'b1;
            cnt_r <= '0;
          end else if (run_r) begin
            cnt_r <= cnt_r + 1'b1;
            if (cnt_r == CW'(NSTEP - 1)) begin
              run_r  <= 1'b0;
              done_r <= 1'b1;
            end
          end
        end
      end

      always_ff @(posedge clk) begin
        if (go) begin
          q_r   <= PW'(key_in >> HOME_SHIFT);
          rem_r <= '0;
        end else if (run_r) begin
          q_r   <= q_r << R;
          rem_r <= rem_acc;
        end
      end

      assign done = done_r;
      assign home = rem_r;
    end
  endgenerate

endmodule

`default_nettype wire

// ===== rtl/lphm_tables.sv =====
// Key and value stores: one write port, one registered read port each.
// Control comes as lphm_pkg::mem_ctl_t.
`default_nettype none

module lphm_tables #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned KW    = 32,
  parameter int unsigned VW    = 32,
  parameter int unsigned AW    = 9
) (
  input  wire                  clk,
  input  lphm_pkg::mem_ctl_t   ctl,
  input  wire [AW-1:0]         waddr,
  input  wire [KW-1:0]         wkey,
  input  wire [VW-1:0]         wval,
  input  wire [AW-1:0]         raddr,
  output logic [KW-1:0]        rkey,
  output logic [VW-1:0]        rval
);
  import lphm_pkg::*;

  logic [KW-1:0] key_mem [DEPTH];
  logic [VW-1:0] val_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_key) begin
      key_mem[waddr] <= wkey;
    end
    if (ctl.rd_en) begin
      rkey <= key_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_val) begin
      val_mem[waddr] <= wval;
    end
    if (ctl.rd_en) begin
      rval <= val_mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/linear_probe_hash_map.sv =====
// Linear-probe hash map from a KEY_BITS key to a VALUE_BITS value, CAPACITY slots.
// Top level: sequencer; uses lphm_pkg, lphm_home, lphm_tables, assert_macros.svh.
//
// Issue an item by raising start while busy is low; every item returns exactly one
// result, shown for one cycle with out_valid high, and the receiver cannot stall it.
// After reset the key store is swept clear, one slot a cycle, and busy stays high until
// the sweep is done and the first item can be taken. A key of zero is answered at once:
// the result appears the cycle after acceptance (status 3 for an insert, miss for a
// lookup) and a new item may follow immediately. Any other key first has its home
// slot computed, by a mask when CAPACITY is a power of two and otherwise by the
// remainder unit. Then one slot is probed per cycle through the registered read port
// of the key and value stores until the item is resolved, and the next item may be
// issued during the cycle that shows the result. A lightly loaded table needs one or
// two probes; a full table walks all CAPACITY slots.
`default_nettype none

module linear_probe_hash_map #(
  parameter int unsigned CAPACITY   = 512,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    start,
  output logic                   busy,
  input  wire                    in_command,
  input  wire [KEY_BITS-1:0]     in_lookup_key,
  input  wire [VALUE_BITS-1:0]   in_entry_value,
  output logic                   out_valid,
  output logic [1:0]             out_status,
  output logic [VALUE_BITS-1:0]  out_read_value
);
  import lphm_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned AW       = $clog2(CAPACITY);
  localparam logic [AW-1:0] LAST   = AW'(CAPACITY - 1);

  state_t                 state_r, state_nxt;
  logic [AW-1:0]          clr_r, clr_nxt;
  logic [AW-1:0]          cur_r, cur_nxt;
  logic [AW-1:0]          cnt_r, cnt_nxt;
  logic                   cmd_r, cmd_nxt;
  logic [KEY_BITS-1:0]    key_r, key_nxt;
  logic [VALUE_BITS-1:0]  val_r, val_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [1:0]             out_status_r, out_status_nxt;
  logic [VALUE_BITS-1:0]  out_value_r, out_value_nxt;

  logic                   hash_go;
  logic                   home_done;
  logic [AW-1:0]          home;
  logic [AW-1:0]          slot_next;
  mem_ctl_t               mem_ctl;
  logic [AW-1:0]          mem_waddr;
  logic [KEY_BITS-1:0]    mem_wkey;
  logic [AW-1:0]          mem_raddr;
  logic [KEY_BITS-1:0]    rkey;
  logic [VALUE_BITS-1:0]  rval;
  logic                   slot_empty;
  logic                   slot_match;

  lphm_home #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS),
    .AW       (AW)
  ) u_home (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (hash_go),
    .key_in (in_lookup_key),
    .done   (home_done),
    .home   (home)
  );

  lphm_tables #(
    .DEPTH (CAPACITY),
    .KW    (KEY_BITS),
    .VW    (VALUE_BITS),
    .AW    (AW)
  ) u_tables (
    .clk   (clk),
    .ctl   (mem_ctl),
    .waddr (mem_waddr),
    .wkey  (mem_wkey),
    .wval  (val_r),
    .raddr (mem_raddr),
    .rkey  (rkey),
    .rval  (rval)
  );

  // advance with wrap from the last slot to slot 0
  assign slot_next  = (cur_r == LAST) ? '0 : cur_r + 1'b1;
  assign slot_empty = (rkey == '0);
  assign slot_match = (rkey == key_r);

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_value_r;

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    cur_nxt        = cur_r;
    cnt_nxt        = cnt_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    hash_go        = 1'b0;
    mem_ctl        = '0;
    mem_waddr      = cur_r;
    mem_wkey       = key_r;
    mem_raddr      = slot_next;

    unique case (state_r)
      S_CLEAR: begin
        // sweep the key store to empty; values are never read before written
        mem_ctl.wr_key = 1'b1;
        mem_waddr      = clr_r;
        mem_wkey       = '0;
        if (clr_r == LAST) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (start) begin
          cmd_nxt = in_command;
          key_nxt = in_lookup_key;
          val_nxt = in_entry_value;
          if (in_lookup_key == '0) begin
            // reserved key: answer without touching the table
            out_valid_nxt  = 1'b1;
            out_status_nxt = (in_command == CMD_INSERT) ? STAT_ZERO : STAT_MISS;
            out_value_nxt  = '0;
          end else begin
            hash_go   = 1'b1;
            state_nxt = S_HASH;
          end
        end
      end

      S_HASH: begin
        if (home_done) begin
          // read the home slot; its data arrives in the first probe cycle
          mem_ctl.rd_en = 1'b1;
          mem_raddr     = home;
          cur_nxt       = home;
          cnt_nxt       = '0;
          state_nxt     = S_PROBE;
        end
      end

      S_PROBE: begin
        // check the slot read last cycle, read the following one speculatively
        mem_ctl.rd_en = 1'b1;
        cur_nxt       = slot_next;
        cnt_nxt       = cnt_r + 1'b1;
        if (cmd_r == CMD_INSERT && (slot_empty || slot_match)) begin
          mem_ctl.wr_key = 1'b1;
          mem_ctl.wr_val = 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_OK;
          out_value_nxt  = '0;
          state_nxt      = S_IDLE;
        end else if (cmd_r == CMD_LOOKUP && slot_empty) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_MISS;
          out_value_nxt  = '0;
          state_nxt      = S_IDLE;
        end else if (cmd_r == CMD_LOOKUP && slot_match) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_OK;
          out_value_nxt  = rval;
          state_nxt      = S_IDLE;
        end else if (cnt_r == LAST) begin
          // every slot visited
          out_valid_nxt  = 1'b1;
          out_status_nxt = (cmd_r == CMD_INSERT) ? STAT_FULL : STAT_MISS;
          out_value_nxt  = '0;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and walk registers: no reset needed
  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    cnt_r        <= cnt_nxt;
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
  end

  `ASSERT_NEXT(a_accept_to_hash, (start && !busy && in_lookup_key != '0), (state_r == S_HASH), "nonzero key did not enter hashing")
  `ASSERT_IMPLIES(a_home_in_hash, home_done, (state_r == S_HASH), "home slot ready outside hashing")
  `ASSERT_IMPLIES(a_write_phase, (mem_ctl.wr_key || mem_ctl.wr_val), (state_r == S_CLEAR || state_r == S_PROBE), "store written outside clear or probe")
  `ASSERT_IMPLIES(a_full_is_insert, (out_valid && out_status == STAT_FULL), (cmd_r == CMD_INSERT), "full status on a lookup")
  `ASSERT_IMPLIES(a_value_on_hit, (out_valid && out_read_value != '0), (out_status == STAT_OK), "value returned without a hit")

endmodule

`default_nettype wire
